/* src/tcau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcau_pkg
// Shared types, constants and the CP437 glyph table for the text cell to
// ANSI/UTF-8 converter.
// ----------------------------------------------------------------------------
package tcau_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_CELL   = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Segment slots of a job, emitted in slot order
    localparam int unsigned SEG_FG    = 0;
    localparam int unsigned SEG_BOLD  = 1;
    localparam int unsigned SEG_BG    = 2;
    localparam int unsigned SEG_BLINK = 3;
    localparam int unsigned SEG_GLYPH = 4;
    localparam int unsigned SEG_EOL   = 5;
    localparam int unsigned SEG_RST   = 6;
    localparam int unsigned SEG_NL    = 7;
    localparam int unsigned NUM_SEG   = 8;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_0   = 8'h30;

    localparam logic [3:0] COLOR_UNKNOWN = 4'd8;
    localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;
    localparam logic [6:0] LINE_WIDTH_RESET = 7'd80;

    // One classified item handed from front to back
    typedef struct packed {
        logic [NUM_SEG-1:0] mask;      // segments to emit
        logic [3:0][7:0]    sgr_tens;  // tens digit of each attribute code
        logic [3:0][7:0]    sgr_ones;  // ones digit of each attribute code
        logic [3:0]         sgr_two;   // code has two digits
        logic [2:0][7:0]    glyph;     // UTF-8 bytes, first at index 0
        logic [1:0]         glyph_len; // 1..3
    } t_job;

    // CGA color index to ANSI color number
    localparam logic [2:0] CGA_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    localparam logic [15:0] GLYPH [256] = '{
        16'h0020, 16'h263a, 16'h263b, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25d8, 16'h25cb, 16'h25d9, 16'h2642, 16'h2640, 16'h266a, 16'h266b, 16'h263c,
        16'h25ba, 16'h25c4, 16'h2195, 16'h203c, 16'h00b6, 16'h00a7, 16'h25ac, 16'h21a8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221f, 16'h2194, 16'h25b2, 16'h25bc,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h005c, 16'h005d, 16'h005e, 16'h005f,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'h007b, 16'h007c, 16'h007d, 16'h007e, 16'h2302,
        16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
        16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
        16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
        16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
        16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
        16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
        16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
        16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
        16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
        16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
        16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
        16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
        16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
    };

endpackage

/* src/tcau_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcau_front
// Classifies each accepted word, tracks the attributes last sent and the
// column, and builds a job of segments for the back end.
// ----------------------------------------------------------------------------
module tcau_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_attr,
    input  logic [6:0]        i_line_width,
    output logic              o_push,
    output tcau_pkg::t_job    o_job
);

    logic [3:0] r_fg, n_fg, r_bg, n_bg;
    logic [1:0] r_bold, n_bold, r_blink, n_blink;
    logic [6:0] r_col, n_col;

    logic [2:0]  fg, bg;
    logic        bo, bl;
    logic [15:0] cp;
    logic [6:0]  col_inc, width;
    logic        eol;

    assign fg = i_attr[2:0];
    assign bo = i_attr[3];
    assign bg = i_attr[6:4];
    assign bl = i_attr[7];
    assign cp = tcau_pkg::GLYPH[i_char_code];
    assign width   = (i_line_width == 7'd0) ? 7'd1 : i_line_width;
    assign col_inc = r_col + 7'd1;
    assign eol     = (col_inc == 7'd0) || (col_inc >= width);

    // Classify the word and compute next tracking state
    always_comb begin
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_bold  = r_bold;
        n_blink = r_blink;
        n_col   = r_col;
        o_job   = '0;
        o_push  = 1'b0;

        // attribute codes: fg 3x, bold 22/1, bg 4x, blink 25/5
        o_job.sgr_tens[tcau_pkg::SEG_FG]    = 8'h33;
        o_job.sgr_ones[tcau_pkg::SEG_FG]    = tcau_pkg::CH_0 + {5'd0, tcau_pkg::CGA_MAP[fg]};
        o_job.sgr_two[tcau_pkg::SEG_FG]     = 1'b1;
        o_job.sgr_tens[tcau_pkg::SEG_BOLD]  = 8'h32;
        o_job.sgr_ones[tcau_pkg::SEG_BOLD]  = bo ? 8'h31 : 8'h32;
        o_job.sgr_two[tcau_pkg::SEG_BOLD]   = !bo;
        o_job.sgr_tens[tcau_pkg::SEG_BG]    = 8'h34;
        o_job.sgr_ones[tcau_pkg::SEG_BG]    = tcau_pkg::CH_0 + {5'd0, tcau_pkg::CGA_MAP[bg]};
        o_job.sgr_two[tcau_pkg::SEG_BG]     = 1'b1;
        o_job.sgr_tens[tcau_pkg::SEG_BLINK] = 8'h32;
        o_job.sgr_ones[tcau_pkg::SEG_BLINK] = 8'h35;
        o_job.sgr_two[tcau_pkg::SEG_BLINK]  = !bl;

        // UTF-8 encode the code point
        if (cp < 16'h0080) begin
            o_job.glyph[0]  = cp[7:0];
            o_job.glyph_len = 2'd1;
        end else if (cp < 16'h0800) begin
            o_job.glyph[0]  = 8'hC0 | {3'd0, cp[10:6]};
            o_job.glyph[1]  = 8'h80 | {2'd0, cp[5:0]};
            o_job.glyph_len = 2'd2;
        end else begin
            o_job.glyph[0]  = 8'hE0 | {4'd0, cp[15:12]};
            o_job.glyph[1]  = 8'h80 | {2'd0, cp[11:6]};
            o_job.glyph[2]  = 8'h80 | {2'd0, cp[5:0]};
            o_job.glyph_len = 2'd3;
        end

        unique case (tcau_pkg::t_req'(i_req_type))
            tcau_pkg::REQ_START: begin
                o_push = 1'b1;
                o_job.mask[tcau_pkg::SEG_RST] = 1'b1;
                o_job.mask[tcau_pkg::SEG_NL]  = 1'b1;
                n_fg = tcau_pkg::COLOR_UNKNOWN; n_bg = tcau_pkg::COLOR_UNKNOWN;
                n_bold = tcau_pkg::LEVEL_UNKNOWN; n_blink = tcau_pkg::LEVEL_UNKNOWN;
                n_col = 7'd0;
            end
            tcau_pkg::REQ_CELL: begin
                o_push = 1'b1;
                o_job.mask[tcau_pkg::SEG_FG]    = ({1'b0, fg} != r_fg);
                o_job.mask[tcau_pkg::SEG_BOLD]  = ({1'b0, bo} != r_bold);
                o_job.mask[tcau_pkg::SEG_BLINK] = ({1'b0, bl} != r_blink);
                o_job.mask[tcau_pkg::SEG_BG]    = ({1'b0, bg} != r_bg);
                o_job.mask[tcau_pkg::SEG_GLYPH] = 1'b1;
                o_job.mask[tcau_pkg::SEG_EOL]   = eol;
                n_fg    = {1'b0, fg};
                n_bold  = {1'b0, bo};
                n_blink = {1'b0, bl};
                n_bg    = eol ? tcau_pkg::COLOR_UNKNOWN : {1'b0, bg};
                n_col   = eol ? 7'd0 : col_inc;
            end
            tcau_pkg::REQ_FINISH: begin
                o_push = 1'b1;
                o_job.mask[tcau_pkg::SEG_EOL] = (r_col != 7'd0);
                o_job.mask[tcau_pkg::SEG_RST] = 1'b1;
                n_fg = tcau_pkg::COLOR_UNKNOWN; n_bg = tcau_pkg::COLOR_UNKNOWN;
                n_bold = tcau_pkg::LEVEL_UNKNOWN; n_blink = tcau_pkg::LEVEL_UNKNOWN;
                n_col = 7'd0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        o_push = o_push && i_accept;
    end

    // Hold tracking state, advance on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= tcau_pkg::COLOR_UNKNOWN;
            r_bg    <= tcau_pkg::COLOR_UNKNOWN;
            r_bold  <= tcau_pkg::LEVEL_UNKNOWN;
            r_blink <= tcau_pkg::LEVEL_UNKNOWN;
            r_col   <= 7'd0;
        end else if (i_accept) begin
            r_fg    <= n_fg;
            r_bg    <= n_bg;
            r_bold  <= n_bold;
            r_blink <= n_blink;
            r_col   <= n_col;
        end
    end

endmodule

/* src/tcau_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcau_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module tcau_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcau_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tcau_pkg::t_job o_job
);

    tcau_pkg::t_job r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* src/tcau_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcau_back
// Walks the segments of the head job and emits one byte per cycle into
// the output register while a job is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module tcau_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tcau_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);

    logic [tcau_pkg::NUM_SEG-1:0] r_done, n_done;
    logic [2:0] r_pos, n_pos;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;

    logic [tcau_pkg::NUM_SEG-1:0] left;
    logic [2:0] seg, len;
    logic       step, seg_end, any;

    assign left    = i_job.mask & ~r_done;
    assign step    = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_out_byte = r_byte;
    assign o_last  = r_last;

    // Pick the current segment and its byte
    always_comb begin
        seg = 3'd0;
        any = 1'b0;
        for (int i = tcau_pkg::NUM_SEG - 1; i >= 0; i--) begin
            if (left[i]) begin
                seg = 3'(i);
                any = 1'b1;
            end
        end
        n_byte = tcau_pkg::CH_ESC;
        len    = 3'd1;
        if (seg < 3'd4) begin
            len = i_job.sgr_two[seg[1:0]] ? 3'd5 : 3'd4;
            unique case (r_pos)
                3'd0: n_byte = tcau_pkg::CH_ESC;
                3'd1: n_byte = tcau_pkg::CH_LBR;
                3'd2: n_byte = i_job.sgr_two[seg[1:0]] ? i_job.sgr_tens[seg[1:0]]
                                                       : i_job.sgr_ones[seg[1:0]];
                3'd3: n_byte = i_job.sgr_two[seg[1:0]] ? i_job.sgr_ones[seg[1:0]]
                                                       : tcau_pkg::CH_M;
                default: n_byte = tcau_pkg::CH_M;
            endcase
        end else if (seg == 3'(tcau_pkg::SEG_GLYPH)) begin
            len = {1'b0, i_job.glyph_len};
            unique case (r_pos)
                3'd0:    n_byte = i_job.glyph[0];
                3'd1:    n_byte = i_job.glyph[1];
                default: n_byte = i_job.glyph[2];
            endcase
        end else if (seg == 3'(tcau_pkg::SEG_EOL)) begin
            len = 3'd6;
            unique case (r_pos)
                3'd0:    n_byte = tcau_pkg::CH_ESC;
                3'd1:    n_byte = tcau_pkg::CH_LBR;
                3'd2:    n_byte = 8'h34;
                3'd3:    n_byte = 8'h39;
                3'd4:    n_byte = tcau_pkg::CH_M;
                default: n_byte = tcau_pkg::CH_NL;
            endcase
        end else if (seg == 3'(tcau_pkg::SEG_RST)) begin
            len = 3'd4;
            unique case (r_pos)
                3'd0:    n_byte = tcau_pkg::CH_ESC;
                3'd1:    n_byte = tcau_pkg::CH_LBR;
                3'd2:    n_byte = tcau_pkg::CH_0;
                default: n_byte = tcau_pkg::CH_M;
            endcase
        end else begin
            len    = 3'd1;
            n_byte = tcau_pkg::CH_NL;
        end

        seg_end = (r_pos == len - 3'd1);
        n_done  = r_done;
        n_pos   = r_pos + 3'd1;
        if (seg_end) begin
            n_done[seg] = 1'b1;
            n_pos = 3'd0;
        end
        n_last = seg_end && ((left & ~(tcau_pkg::NUM_SEG'(1) << seg)) == '0);
        o_pop  = step && any && n_last;
        if (o_pop) begin
            n_done = '0;
        end
    end

    // Advance the walk, load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_pos   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_done  <= n_done;
                r_pos   <= n_pos;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

endmodule

/* src/text_cell_to_ansi_utf8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_to_ansi_utf8
// Converts CP437 text cells with CGA attributes into an ANSI/UTF-8 byte
// stream.
// ----------------------------------------------------------------------------
// The output carries one byte per cycle while the receiver is ready: a
// plain cell has 1 to 3 bytes, up to 29 with four attribute changes and a
// line end; start has 5 bytes and finish 4 or 10. The front end classifies
// an accepted word combinationally and queues up to two classified jobs, so
// input and output stall independently; the output byte register sets the rate.
// line_width may be written any time the block is idle.
module text_cell_to_ansi_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_attr,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_line_width
);

    logic [6:0]     r_line_width;
    logic           full, empty, push, pop, accept;
    tcau_pkg::t_job f_job, q_job;

    assign o_ready     = !full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !full;

    // Hold the line width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= tcau_pkg::LINE_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_line_width <= i_cfg_line_width;
        end
    end

    tcau_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .i_line_width (r_line_width),
        .o_push       (push),
        .o_job        (f_job)
    );

    tcau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (q_job)
    );

    tcau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for text_cell_to_ansi_utf8. A behavioral predictor computes the
// ANSI/UTF-8 bytes for every accepted request word; a checker compares each
// output byte and its last flag with the oldest predicted byte. Directed
// cases cover start, finish, attribute changes, glyph widths, the ignored
// request code, line widths 0, 1 and 127 and lowered widths; random screens
// run under varying backpressure, then a long receiver stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = tcau_pkg::REQ_NONE;
    logic [7:0] char_code = 8'd0;
    logic [7:0] attr = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_width = 7'd80;

    // predictor state
    logic [6:0] pred_width;
    logic [3:0] pred_fg;
    logic [1:0] pred_bold;
    logic [3:0] pred_bg;
    logic [1:0] pred_blink;
    logic [6:0] pred_column;
    logic [8:0] expected_bytes[$];   // {last, byte}
    logic [8:0] pending_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;      // bumped by a test to start a long receiver stall
    int hold_seen = 0;
    int hold_left = 0;
    bit failed = 1'b0;

    localparam logic [7:0] ANSI_COLOR [8] = '{8'd0, 8'd4, 8'd2, 8'd6, 8'd1, 8'd5, 8'd3, 8'd7};

    text_cell_to_ansi_utf8 dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_req_type(req_type), .i_char_code(char_code), .i_attr(attr),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_out_byte(out_byte), .o_last(out_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_line_width(cfg_width)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        pending_bytes.push_back({1'b0, b});
    endfunction

    function automatic void push_sgr(input logic [7:0] n);
        push_byte(tcau_pkg::CH_ESC);
        push_byte(tcau_pkg::CH_LBR);
        if (n >= 8'd10) push_byte(tcau_pkg::CH_0 + n / 8'd10);
        push_byte(tcau_pkg::CH_0 + n % 8'd10);
        push_byte(tcau_pkg::CH_M);
    endfunction

    function automatic void push_glyph(input logic [7:0] code);
        logic [15:0] cp;
        cp = tcau_pkg::GLYPH[code];
        if (cp < 16'h80) begin
            push_byte(cp[7:0]);
        end else if (cp < 16'h800) begin
            push_byte(8'hC0 | {3'd0, cp[10:6]});
            push_byte(8'h80 | {2'd0, cp[5:0]});
        end else begin
            push_byte(8'hE0 | {4'd0, cp[15:12]});
            push_byte(8'h80 | {2'd0, cp[11:6]});
            push_byte(8'h80 | {2'd0, cp[5:0]});
        end
    endfunction

    function automatic void close_line();
        pred_bg = tcau_pkg::COLOR_UNKNOWN;
        push_sgr(8'd49);
        push_byte(tcau_pkg::CH_NL);
        pred_column = 7'd0;
    endfunction

    function automatic void forget_attrs();
        pred_fg = tcau_pkg::COLOR_UNKNOWN;
        pred_bold = tcau_pkg::LEVEL_UNKNOWN;
        pred_bg = tcau_pkg::COLOR_UNKNOWN;
        pred_blink = tcau_pkg::LEVEL_UNKNOWN;
    endfunction

    function automatic void predict_word(input logic [1:0] rq, input logic [7:0] ch,
                                         input logic [7:0] at);
        logic [6:0] w;
        w = (pred_width == 7'd0) ? 7'd1 : pred_width;
        pending_bytes.delete();
        case (rq)
            tcau_pkg::REQ_START: begin
                push_sgr(8'd0);
                push_byte(tcau_pkg::CH_NL);
                forget_attrs();
                pred_column = 7'd0;
            end
            tcau_pkg::REQ_CELL: begin
                if ({1'b0, at[2:0]} != pred_fg) begin
                    pred_fg = {1'b0, at[2:0]};
                    push_sgr(8'd30 + ANSI_COLOR[at[2:0]]);
                end
                if ({1'b0, at[3]} != pred_bold) begin
                    pred_bold = {1'b0, at[3]};
                    push_sgr(at[3] ? 8'd1 : 8'd22);
                end
                if ({1'b0, at[6:4]} != pred_bg) begin
                    pred_bg = {1'b0, at[6:4]};
                    push_sgr(8'd40 + ANSI_COLOR[at[6:4]]);
                end
                if ({1'b0, at[7]} != pred_blink) begin
                    pred_blink = {1'b0, at[7]};
                    push_sgr(at[7] ? 8'd5 : 8'd25);
                end
                push_glyph(ch);
                pred_column = pred_column + 7'd1;
                if (pred_column == 7'd0 || pred_column >= w) close_line();
            end
            tcau_pkg::REQ_FINISH: begin
                if (pred_column != 7'd0) close_line();
                push_sgr(8'd0);
                forget_attrs();
                pred_column = 7'd0;
            end
            default: ;
        endcase
        if (pending_bytes.size() > 0) pending_bytes[$][8] = 1'b1;
        foreach (pending_bytes[k]) expected_bytes.push_back(pending_bytes[k]);
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // Called at a falling edge; leaves valid high so words can follow
    // back to back. Whoever pauses the sender drops valid first.
    task automatic send_word(input logic [1:0] rq, input logic [7:0] ch,
                             input logic [7:0] at);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        char_code <= ch;
        attr <= at;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(rq, ch, at);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_width(input logic [6:0] w);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_width <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pred_width = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_attr();
        // mostly repeat a small palette so runs without escapes occur
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'h07 | (8'($urandom_range(1)) << 4);
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        logic [8:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: byte expected none actual %02h last %0d",
                         $time, out_byte, out_last);
                failed = 1'b1;
            end else begin
                want = expected_bytes.pop_front();
                if (want[7:0] !== out_byte) begin
                    $display("%0t: byte expected %02h actual %02h", $time, want[7:0], out_byte);
                    failed = 1'b1;
                end
                if (want[8] !== out_last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want[8], out_last);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_word(tcau_pkg::REQ_START, 8'h00, 8'h00);
        send_word(tcau_pkg::REQ_CELL, 8'h00, 8'h00);       // code zero shows a space
        send_word(tcau_pkg::REQ_CELL, 8'h41, 8'h00);       // no attribute change
        send_word(tcau_pkg::REQ_CELL, 8'hFF, 8'hFF);       // all four attributes change
        send_word(tcau_pkg::REQ_CELL, 8'h80, 8'h5A);       // two-byte glyph
        send_word(tcau_pkg::REQ_CELL, 8'h01, 8'hA5);       // three-byte glyph
        send_word(tcau_pkg::REQ_NONE, 8'hFF, 8'hFF);       // ignored request
        send_word(tcau_pkg::REQ_START, 8'h12, 8'h34);      // start with a partial line
        send_word(tcau_pkg::REQ_CELL, 8'h7F, 8'h7F);
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);     // finish closes the line
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);     // finish at column zero
        write_width(7'd1);
        send_word(tcau_pkg::REQ_CELL, 8'hB3, 8'h1E);
        send_word(tcau_pkg::REQ_CELL, 8'hB3, 8'h1E);
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);
        write_width(7'd0);                                 // zero acts as one
        send_word(tcau_pkg::REQ_CELL, 8'h55, 8'hAA);
        write_width(7'd5);
        for (int i = 0; i < 4; i++) send_word(tcau_pkg::REQ_CELL, 8'(8'h30 + i), 8'(i * 37));
        write_width(7'd2);                                 // lowered below the column
        send_word(tcau_pkg::REQ_CELL, 8'h20, 8'h00);
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);
    endtask

    task automatic test_random_screens(input int words, input logic [6:0] w);
        logic [1:0] rq;
        int n;
        write_width(w);
        n = 0;
        while (n < words) begin
            if (n % 60 == 0) send_word(tcau_pkg::REQ_START, 8'($urandom), 8'($urandom));
            rq = ($urandom_range(29) == 0) ? 2'($urandom) : tcau_pkg::REQ_CELL;
            send_word(rq, 8'($urandom), rand_attr());
            if (rq != tcau_pkg::REQ_NONE) n++;
        end
        send_word(tcau_pkg::REQ_FINISH, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req = hold_req + 1;
        for (int i = 0; i < 30; i++) send_word(tcau_pkg::REQ_CELL, 8'($urandom), 8'($urandom));
        wait_drained();
        for (int i = 0; i < 10; i++) send_word(tcau_pkg::REQ_CELL, 8'($urandom), 8'($urandom));
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);
    endtask

    task automatic test_long_line();
        write_width(7'd127);
        send_word(tcau_pkg::REQ_START, 8'h00, 8'h00);
        for (int i = 0; i < 130; i++) send_word(tcau_pkg::REQ_CELL, 8'($urandom), rand_attr());
        send_word(tcau_pkg::REQ_FINISH, 8'h00, 8'h00);
    endtask

    initial begin
        pred_width = tcau_pkg::LINE_WIDTH_RESET;
        pred_column = 7'd0;
        forget_attrs();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 62;
        test_directed();
        test_random_screens(110, 7'd13);
        send_idle_pct = 62;
        recv_idle_pct = 25;
        test_random_screens(110, 7'd80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_line();
        test_backpressure();
        wait_drained();
        if (!failed) $display("text_cell_to_ansi_utf8 verification clean");
        else $display("text_cell_to_ansi_utf8 verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("text_cell_to_ansi_utf8 verification failed");
        $finish;
    end
endmodule
